// ===== design/qrs_pkg.sv =====
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_FRAC_DEF  = 16;
   localparam int FIELD_W        = 16;
   localparam int ROOT_W         = 32;

   typedef enum logic [1:0] {
      KIND_TWO_REAL   = 2'd0,
      KIND_DOUBLE     = 2'd1,
      KIND_COMPLEX    = 2'd2,
      KIND_DEGENERATE = 2'd3
   } root_kind_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] coef_a;
      logic signed [FIELD_W-1:0] coef_b;
      logic signed [FIELD_W-1:0] coef_c;
   } req_data_type;

   typedef struct packed {
      logic signed [ROOT_W-1:0] root_plus;
      logic signed [ROOT_W-1:0] root_minus;
      root_kind_type            root_kind;
      logic                     saturated;
   } rsp_data_type;

endpackage

// ===== design/qrs_sqrt_pipe.sv =====
module qrs_sqrt_pipe import qrs_pkg::*; #(
   parameter int ROOT_BITS = 34,
   parameter int SIDE_W    = 35
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [2*ROOT_BITS-1:0] in_rad,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int RAD_W = 2*ROOT_BITS;
   localparam int REM_W = ROOT_BITS+2;

   logic                 valid_ff [ROOT_BITS];
   logic [RAD_W-1:0]     rad_ff   [ROOT_BITS];
   logic [REM_W-1:0]     rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [SIDE_W-1:0]    side_ff  [ROOT_BITS];

   // one result bit per stage, restoring digit recurrence
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      logic                 valid_src;
      logic [RAD_W-1:0]     rad_src;
      logic [REM_W-1:0]     rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [SIDE_W-1:0]    side_src;
      logic [REM_W-1:0]     rem_sh;
      logic [REM_W-1:0]     trial;
      logic [REM_W-1:0]     rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rad_src   = in_rad;
         assign rem_src   = '0;
         assign root_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rad_src   = rad_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
         trial  = {root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
         rad_ff[k]  <= {rad_src[RAD_W-3:0], 2'b00};
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule

// ===== design/qrs_div_pipe.sv =====
module qrs_div_pipe import qrs_pkg::*; #(
   parameter int DVD_W  = 37,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DVD_W-1:0]  in_dvd,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DVD_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   localparam int REM_W = DEN_W+1;

   logic              valid_ff [DVD_W];
   logic [DVD_W-1:0]  dvd_ff   [DVD_W];
   logic [DEN_W-1:0]  den_ff   [DVD_W];
   logic [DEN_W-1:0]  rem_ff   [DVD_W];
   logic [DVD_W-1:0]  quot_ff  [DVD_W];
   logic [SIDE_W-1:0] side_ff  [DVD_W];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < DVD_W; k++) begin : g_stage
      logic              valid_src;
      logic [DVD_W-1:0]  dvd_src;
      logic [DEN_W-1:0]  den_src;
      logic [DEN_W-1:0]  rem_src;
      logic [DVD_W-1:0]  quot_src;
      logic [SIDE_W-1:0] side_src;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  rem_sub;
      logic [DEN_W-1:0]  rem_in;
      logic              qbit;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign dvd_src   = in_dvd;
         assign den_src   = in_den;
         assign rem_src   = '0;
         assign quot_src  = '0;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign dvd_src   = dvd_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign quot_src  = quot_ff[k-1];
         assign side_src  = side_ff[k-1];
      end

      always_comb begin
         rem_sh  = {rem_src, dvd_src[DVD_W-1]};
         rem_sub = rem_sh - {1'b0, den_src};
         qbit    = (rem_sh >= {1'b0, den_src});
         rem_in  = qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
         dvd_ff[k]  <= {dvd_src[DVD_W-2:0], 1'b0};
         den_ff[k]  <= den_src;
         rem_ff[k]  <= rem_in;
         quot_ff[k] <= {quot_src[DVD_W-2:0], qbit};
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = valid_ff[DVD_W-1];
   assign out_quot  = quot_ff[DVD_W-1];
   assign out_side  = side_ff[DVD_W-1];

endmodule

// ===== design/quadratic_root_solver.sv =====
// channel | ports                          | handshake
// item in | start, busy, req_data          | taken when start && !busy
// item out| rsp_strobe, rsp_data           | one-cycle strobe, no back-pressure
//
// the pipeline holds R = COEF_WIDTH+ROOT_FRAC_BITS+2 root stages and
// Q = COEF_WIDTH+ROOT_FRAC_BITS+5 divider stages
// one item may enter every cycle; busy stays low
// synchronous reset clears only the valid bits
// the pipeline never stalls since results cannot be held off
module quadratic_root_solver import qrs_pkg::*; #(
   parameter int COEF_WIDTH     = COEF_WIDTH_DEF,
   parameter int ROOT_FRAC_BITS = ROOT_FRAC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_strobe,
   output rsp_data_type rsp_data
);

   localparam int CW     = COEF_WIDTH;
   localparam int F      = ROOT_FRAC_BITS;
   localparam int DW     = 2*CW+3;
   localparam int SQRT_W = (DW+2*F+1)/2;
   localparam int RAD_W  = 2*SQRT_W;
   localparam int BW     = CW+1+F;
   localparam int NW     = ((BW > SQRT_W+1) ? BW : SQRT_W+1) + 1;
   localparam int QUOT_W = NW+1;
   localparam int DEN_W  = CW+1;
   localparam int SSIDE  = 2*CW+3;
   localparam int QX_W   = (QUOT_W > ROOT_W+1) ? QUOT_W : ROOT_W+1;

   logic signed [CW-1:0] a_raw, b_raw, c_raw;

   if (CW <= FIELD_W) begin : g_narrow
      assign a_raw = req_data.coef_a[CW-1:0];
      assign b_raw = req_data.coef_b[CW-1:0];
      assign c_raw = req_data.coef_c[CW-1:0];
   end else begin : g_wide
      assign a_raw = {{(CW-FIELD_W){req_data.coef_a[FIELD_W-1]}}, req_data.coef_a};
      assign b_raw = {{(CW-FIELD_W){req_data.coef_b[FIELD_W-1]}}, req_data.coef_b};
      assign c_raw = {{(CW-FIELD_W){req_data.coef_c[FIELD_W-1]}}, req_data.coef_c};
   end

   assign busy = 1'b0;

   // stage 0: capture
   logic                 v0_ff;
   logic signed [CW-1:0] a0_ff, b0_ff, c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      a0_ff <= a_raw;
      b0_ff <= b_raw;
      c0_ff <= c_raw;
   end

   // stage 1: products of magnitudes
   logic [CW-1:0]        ua0, ub0, uc0;
   logic                 v1_ff, opp1_ff;
   logic signed [CW-1:0] a1_ff, b1_ff;
   logic [2*CW-1:0]      bb1_ff, ac1_ff;

   assign ua0 = a0_ff[CW-1] ? CW'(~a0_ff + 1'b1) : a0_ff;
   assign ub0 = b0_ff[CW-1] ? CW'(~b0_ff + 1'b1) : b0_ff;
   assign uc0 = c0_ff[CW-1] ? CW'(~c0_ff + 1'b1) : c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      bb1_ff  <= ub0 * ub0;
      ac1_ff  <= ua0 * uc0;
      opp1_ff <= (c0_ff != '0) && (a0_ff[CW-1] != c0_ff[CW-1]);
      a1_ff   <= a0_ff;
      b1_ff   <= b0_ff;
   end

   // stage 2: discriminant magnitude and kind
   logic [DW-1:0]        bb_ext, ac4_ext, d_in;
   logic                 neg_in;
   root_kind_type        kind_in;
   logic                 v2_ff;
   logic [DW-1:0]        d2_ff;
   root_kind_type        kind2_ff;
   logic signed [CW-1:0] a2_ff, b2_ff;

   always_comb begin
      bb_ext  = DW'(bb1_ff);
      ac4_ext = DW'({ac1_ff, 2'b00});
      neg_in  = 1'b0;
      if (opp1_ff) begin
         d_in = bb_ext + ac4_ext;
      end else if (bb_ext >= ac4_ext) begin
         d_in = bb_ext - ac4_ext;
      end else begin
         d_in   = ac4_ext - bb_ext;
         neg_in = 1'b1;
      end
      if (a1_ff == '0) begin
         kind_in = KIND_DEGENERATE;
      end else if (d_in == '0) begin
         kind_in = KIND_DOUBLE;
      end else if (neg_in) begin
         kind_in = KIND_COMPLEX;
      end else begin
         kind_in = KIND_TWO_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      d2_ff    <= d_in;
      kind2_ff <= kind_in;
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
   end

   // square root of |d| scaled by 2^(2F)
   logic [RAD_W-1:0]  rad;
   logic              vs;
   logic [SQRT_W-1:0] root_s;
   logic [SSIDE-1:0]  side_s;

   assign rad = RAD_W'({d2_ff, {(2*F){1'b0}}});

   qrs_sqrt_pipe #(
      .ROOT_BITS (SQRT_W),
      .SIDE_W    (SSIDE)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rad    (rad),
      .in_side   ({a2_ff, b2_ff, kind2_ff, 1'b0}),
      .out_valid (vs),
      .out_root  (root_s),
      .out_side  (side_s)
   );

   // stage 3: numerators and divider operands
   logic signed [CW-1:0] a_s, b_s;
   logic [1:0]           kind_s;
   logic [CW-1:0]        ua_s;
   logic signed [NW-1:0] base, s_ext, np, nm;
   logic [NW-1:0]        mp, mm;
   logic                 v3_ff, negp3_ff, negm3_ff;
   logic [QUOT_W-1:0]    dvp3_ff, dvm3_ff;
   logic [DEN_W-1:0]     den3_ff;
   logic [1:0]           kind3_ff;

   always_comb begin
      a_s    = side_s[SSIDE-1 -: CW];
      b_s    = side_s[SSIDE-1-CW -: CW];
      kind_s = side_s[2:1];
      ua_s   = a_s[CW-1] ? CW'(~a_s + 1'b1) : a_s;
      base   = -(NW'(b_s) <<< F);
      s_ext  = signed'(NW'(root_s));
      np     = base + s_ext;
      nm     = base - s_ext;
      mp     = np[NW-1] ? NW'(~np + 1'b1) : np;
      mm     = nm[NW-1] ? NW'(~nm + 1'b1) : nm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= vs;
      end
      // adding |a| rounds the quotient by 2|a| to nearest
      dvp3_ff  <= QUOT_W'(mp) + QUOT_W'(ua_s);
      dvm3_ff  <= QUOT_W'(mm) + QUOT_W'(ua_s);
      den3_ff  <= {ua_s, 1'b0};
      negp3_ff <= np[NW-1] ^ a_s[CW-1];
      negm3_ff <= nm[NW-1] ^ a_s[CW-1];
      kind3_ff <= kind_s;
   end

   logic              vq, vq_m;
   logic [QUOT_W-1:0] qp, qm;
   logic [2:0]        side_p;
   logic              side_m;

   qrs_div_pipe #(
      .DVD_W  (QUOT_W),
      .DEN_W  (DEN_W),
      .SIDE_W (3)
   ) u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_dvd    (dvp3_ff),
      .in_den    (den3_ff),
      .in_side   ({kind3_ff, negp3_ff}),
      .out_valid (vq),
      .out_quot  (qp),
      .out_side  (side_p)
   );

   qrs_div_pipe #(
      .DVD_W  (QUOT_W),
      .DEN_W  (DEN_W),
      .SIDE_W (1)
   ) u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_dvd    (dvm3_ff),
      .in_den    (den3_ff),
      .in_side   (negm3_ff),
      .out_valid (vq_m),
      .out_quot  (qm),
      .out_side  (side_m)
   );

   // final stage: sign, clamp, degenerate override
   logic [QX_W-1:0]   qpx, qmx, lim_pos, lim_neg;
   logic [ROOT_W-1:0] rp_in, rm_in;
   logic              satp, satm;
   root_kind_type     kind_f;
   logic              strobe_ff;
   rsp_data_type      rsp_ff;

   always_comb begin
      qpx     = QX_W'(qp);
      qmx     = QX_W'(qm);
      lim_pos = QX_W'({1'b0, {(ROOT_W-1){1'b1}}});
      lim_neg = QX_W'({1'b1, {(ROOT_W-1){1'b0}}});
      kind_f  = root_kind_type'(side_p[2:1]);
      if (side_p[0]) begin
         satp  = qpx > lim_neg;
         rp_in = satp ? lim_neg[ROOT_W-1:0] : ROOT_W'(~qpx[ROOT_W-1:0] + 1'b1);
      end else begin
         satp  = qpx > lim_pos;
         rp_in = satp ? lim_pos[ROOT_W-1:0] : qpx[ROOT_W-1:0];
      end
      if (side_m) begin
         satm  = qmx > lim_neg;
         rm_in = satm ? lim_neg[ROOT_W-1:0] : ROOT_W'(~qmx[ROOT_W-1:0] + 1'b1);
      end else begin
         satm  = qmx > lim_pos;
         rm_in = satm ? lim_pos[ROOT_W-1:0] : qmx[ROOT_W-1:0];
      end
      if (kind_f == KIND_DEGENERATE) begin
         rp_in = '0;
         rm_in = '0;
         satp  = 1'b0;
         satm  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vq && vq_m;
      end
      rsp_ff.root_plus  <= rp_in;
      rsp_ff.root_minus <= rm_in;
      rsp_ff.root_kind  <= kind_f;
      rsp_ff.saturated  <= satp || satm;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== design/qrs_checker.sv =====
module qrs_checker import qrs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_data_type rsp_data
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.root_kind == KIND_DEGENERATE |->
         rsp_data.root_plus == '0 && rsp_data.root_minus == '0 && !rsp_data.saturated)
      else $error("degenerate item with nonzero roots");

   a_double: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.root_kind == KIND_DOUBLE |->
         rsp_data.root_plus == rsp_data.root_minus)
      else $error("double root with unequal roots");

   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.saturated |->
         rsp_data.root_plus == {1'b0, {(ROOT_W-1){1'b1}}} ||
         rsp_data.root_plus == {1'b1, {(ROOT_W-1){1'b0}}} ||
         rsp_data.root_minus == {1'b0, {(ROOT_W-1){1'b1}}} ||
         rsp_data.root_minus == {1'b1, {(ROOT_W-1){1'b0}}})
      else $error("saturated flag without a clamped root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ===== bench/testbench.sv =====
module testbench;
   import qrs_pkg::*;

   localparam int DRAIN_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;

   // expected roots for accepted coefficient sets, oldest first
   class root_scoreboard;
      rsp_data_type pending_roots[$];
      int mismatches;

      function automatic longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      // rounded, clamped num / (2a)
      function automatic logic [31:0] div_round(longint num, longint a, ref bit sat);
         longint den, q;
         bit neg;
         den = 2 * mag(a);
         q = (mag(num) + den / 2) / den;
         neg = (num < 0) != (a < 0);
         if (!neg) begin
            if (q > 64'sh7FFF_FFFF) begin
               sat = 1;
               q = 64'sh7FFF_FFFF;
            end
            return q[31:0];
         end
         if (q > 64'sh8000_0000) begin
            sat = 1;
            q = 64'sh8000_0000;
         end
         return 32'(-q);
      endfunction

      function automatic logic [63:0] isqrt(logic [127:0] v);
         logic [63:0] r, t;
         r = 0;
         for (int bitpos = 57; bitpos >= 0; bitpos--) begin
            t = r | (64'd1 << bitpos);
            if ({64'd0, t} * {64'd0, t} <= v) r = t;
         end
         return r;
      endfunction

      function void note_coefs(req_data_type coefs);
         rsp_data_type roots;
         longint a, b, c, base;
         logic signed [127:0] disc;
         logic [127:0] disc_mag;
         logic [63:0] root;
         bit sat;
         a = coefs.coef_a;
         b = coefs.coef_b;
         c = coefs.coef_c;
         sat = 0;
         if (a == 0) begin
            roots = '{root_plus: 0, root_minus: 0, root_kind: KIND_DEGENERATE, saturated: 0};
         end else begin
            disc = 128'(b * b) - 128'(4 * a * c);
            disc_mag = disc < 0 ? -disc : disc;
            if (disc == 0) roots.root_kind = KIND_DOUBLE;
            else if (disc < 0) roots.root_kind = KIND_COMPLEX;
            else roots.root_kind = KIND_TWO_REAL;
            root = isqrt(disc_mag << 32);
            base = -b * 65536;
            roots.root_plus = div_round(base + longint'(root), a, sat);
            roots.root_minus = div_round(base - longint'(root), a, sat);
            roots.saturated = sat;
         end
         pending_roots.push_back(roots);
      endfunction

      function void check_roots(rsp_data_type got);
         rsp_data_type want;
         if (pending_roots.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending_roots.pop_front();
         if (got.root_plus !== want.root_plus || got.root_minus !== want.root_minus
               || got.root_kind !== want.root_kind || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic rsp_strobe;
   req_data_type req_data = '0;
   rsp_data_type rsp_data;
   root_scoreboard board = new();
   int idle_cycles = 0;
   int send_idle_pct = 0;

   quadratic_root_solver uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_coefs(req_data);
         if (rsp_strobe) board.check_roots(rsp_data);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 8)) - 4);
         4: return 16'(int'($urandom_range(0, 1024)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_data <= '{coef_a: a, coef_b: b, coef_c: c};
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random(int count);
      logic [15:0] a, b, c;
      for (int i = 0; i < count; i++) begin
         a = pick_coef();
         b = pick_coef();
         // sometimes aim at a zero discriminant: a=1.0, c=b*b/4 scaled
         if ($urandom_range(0, 15) == 0) begin
            a = 16'h0100;
            b = 16'(2 * (int'($urandom_range(0, 60)) - 30));
            c = 16'((int'(signed'(b)) / 2) * (int'(signed'(b)) / 2) / 256);
            if (((int'(signed'(b)) / 2) * (int'(signed'(b)) / 2)) % 256 != 0) c = pick_coef();
         end else begin
            c = pick_coef();
         end
         send_coefs(a, b, c);
      end
   endtask

   task automatic wait_drained();
      while (board.pending_roots.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: degenerate, double, complex, two real, extremes
      send_coefs(16'h0000, 16'h1234, 16'h5678);
      send_coefs(16'h0100, 16'hFC00, 16'h0400);
      send_coefs(16'h0100, 16'h0000, 16'h0100);
      send_coefs(16'h0100, 16'h0000, 16'hFF00);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_coefs(16'h0001, 16'h7FFF, 16'h0000);
      send_coefs(16'h0001, 16'h8000, 16'h7FFF);
      send_coefs(16'hFFFF, 16'h8000, 16'h8000);
      send_coefs(16'h0001, 16'h0000, 16'h8000);
      send_coefs(16'hFFFF, 16'h0001, 16'hFFFF);
      send_coefs(16'h8000, 16'h0000, 16'h0000);
      send_coefs(16'hFFFF, 16'hFFFF, 16'h7FFF);
      send_coefs(16'h0000, 16'hFFFF, 16'hFFFF);
      start <= 0;
      // hold off until everything is back
      wait_drained();
      send_idle_pct = 0;
      send_random(450);
      send_idle_pct = 71;
      send_random(400);
      start <= 0;
      wait_drained();
      send_idle_pct = 34;
      send_random(400);
      send_idle_pct = 0;
      send_random(400);
      start <= 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_roots.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/qrs_pkg.sv
design/qrs_sqrt_pipe.sv
design/qrs_div_pipe.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
bench/testbench.sv
